// ===== rtl/core/mtg_pkg.sv =====
// shared types and constants of the mersenne twister generator
package mtg_pkg;

  localparam int TABLE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = 10;
  localparam int WORD_W       = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam addr_t LAST_IDX      = addr_t'(TABLE_WORDS - 1);
  localparam addr_t POS_EXHAUSTED = addr_t'(TABLE_WORDS);
  localparam addr_t POS_UNSEEDED  = addr_t'(TABLE_WORDS + 1);
  localparam addr_t FAR_STEP      = addr_t'(TWIST_OFFSET);
  localparam addr_t FAR_WRAP      = addr_t'(TABLE_WORDS - TWIST_OFFSET);

  localparam word_t CHAIN_MULT   = 32'd69069;
  localparam word_t MIX_START    = 32'd373737;
  localparam word_t MIX_MULT     = 32'd5531;
  localparam word_t MIX_ADD      = 32'd81547;
  localparam word_t TWIST_MATRIX = 32'h9908b0df;
  localparam word_t HIGH_BIT     = 32'h80000000;
  localparam word_t LOW_BITS     = 32'h7fffffff;
  localparam word_t TEMPER_B     = 32'h9d2c5680;
  localparam word_t TEMPER_C     = 32'hefc60000;

  localparam logic OP_SEED = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  fill_init;
    logic  use_fallback;
    logic  fill_wr;
    logic  fill_first;
    logic  twist_wr;
    logic  cur_load;
    logic  rd_en;
    addr_t rd_addr_a;
    addr_t rd_addr_b;
    addr_t wr_addr;
    logic  res_load;
    logic  res_seed;
  } cmd_t;

endpackage

// ===== rtl/core/mtg_if.sv =====
// handshake channels of the mersenne twister generator
interface mtg_req_if;
  logic          valid;
  logic          ready;
  logic          op;
  mtg_pkg::word_t seed_value;

  modport source (output valid, output op, output seed_value, input ready);
  modport sink (input valid, input op, input seed_value, output ready);
endinterface

interface mtg_rsp_if;
  logic          valid;
  logic          ready;
  mtg_pkg::word_t random_word;
  logic          is_seed_ack;

  modport source (output valid, output random_word, output is_seed_ack, input ready);
  modport sink (input valid, input random_word, input is_seed_ack, output ready);
endinterface

interface mtg_cfg_if;
  logic          valid;
  logic          ready;
  mtg_pkg::word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mersenne_twister_generator.sv =====
// top level of the mt19937 generator: controller, datapath and checks
//
//   channel   dir   word contents              handshake
//   req_i     in    op, seed_value             valid/ready
//   rsp_o     out   random_word, is_seed_ack   valid/ready
//   cfg_i     in    data (fallback seed)       valid/ready, always ready
//
// one command at a time; a draw from a live table goes through a registered table read
// a seed fills one table word per cycle through the seed chain
// a draw on an exhausted table first twists the whole table, one word a cycle;
// a draw before any seed also first fills the table from the fallback seed
// reset needs no clearing pass: the table is only read after a fill
// a finished result waits in the output register while rsp_o is stalled
module mersenne_twister_generator (
  input  logic clk_i,
  input  logic rst_ni,
  mtg_req_if.sink   req_i,
  mtg_rsp_if.source rsp_o,
  mtg_cfg_if.sink   cfg_i
);

  mtg_pkg::cmd_t cmd;
  logic          in_ready;
  logic          out_valid;

  mtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.op),
    .in_ready_o  (in_ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  mtg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seed_value_i  (req_i.seed_value),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .random_word_o (rsp_o.random_word),
    .is_seed_ack_o (rsp_o.is_seed_ack)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;
  assign cfg_i.ready = 1'b1;

  // a seed acknowledgement never carries a random word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.is_seed_ack |-> rsp_o.random_word == '0)
    else $error("seed acknowledgement with nonzero word");

  // once a command is taken the block is busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && in_ready |=> !in_ready)
    else $error("command accepted on back to back cycles");

  // fill and twist never write the table in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.twist_wr |-> !cmd.fill_wr)
    else $error("fill and twist write clash");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.res_load |-> !out_valid || rsp_o.ready)
    else $error("result overwritten before it was taken");

endmodule

// ===== rtl/core/mtg_ctrl.sv =====
// controller state machine: sequences seeding, twisting and draws
module mtg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output mtg_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FILL   = 3'd1;
  localparam logic [2:0] S_TPRIME = 3'd2;
  localparam logic [2:0] S_TLOAD  = 3'd3;
  localparam logic [2:0] S_TRUN   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]     state_q, state_d;
  mtg_pkg::addr_t k_q, k_d;
  mtg_pkg::addr_t pos_q, pos_d;
  logic           op_q, op_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;
  mtg_pkg::addr_t k_next;

  function automatic mtg_pkg::addr_t next_idx(input mtg_pkg::addr_t j);
    return (j == mtg_pkg::LAST_IDX) ? '0 : j + mtg_pkg::addr_t'(1);
  endfunction

  function automatic mtg_pkg::addr_t far_idx(input mtg_pkg::addr_t j);
    return (j < mtg_pkg::FAR_WRAP) ? j + mtg_pkg::FAR_STEP : j - mtg_pkg::FAR_WRAP;
  endfunction

  assign out_free = !out_valid_q || out_ready_i;
  assign k_next   = k_q + mtg_pkg::addr_t'(1);

  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    pos_d      = pos_q;
    op_d       = op_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d = in_op_i;
          if (in_op_i == mtg_pkg::OP_SEED) begin
            cmd_o.fill_init = 1'b1;
            k_d             = '0;
            state_d         = S_FILL;
          end else if (pos_q == mtg_pkg::POS_UNSEEDED) begin
            cmd_o.fill_init    = 1'b1;
            cmd_o.use_fallback = 1'b1;
            k_d                = '0;
            state_d            = S_FILL;
          end else if (pos_q == mtg_pkg::POS_EXHAUSTED) begin
            state_d = S_TPRIME;
          end else begin
            cmd_o.rd_en     = 1'b1;
            cmd_o.rd_addr_a = pos_q;
            pos_d           = pos_q + mtg_pkg::addr_t'(1);
            state_d         = S_DONE;
          end
        end
      end
      S_FILL: begin
        cmd_o.fill_wr    = 1'b1;
        cmd_o.fill_first = (k_q == '0);
        cmd_o.wr_addr    = k_q;
        if (k_q == mtg_pkg::LAST_IDX) begin
          pos_d   = mtg_pkg::POS_EXHAUSTED;
          state_d = (op_q == mtg_pkg::OP_DRAW) ? S_TPRIME : S_DONE;
        end else begin
          k_d = k_next;
        end
      end
      S_TPRIME: begin
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = '0;
        state_d         = S_TLOAD;
      end
      S_TLOAD: begin
        // current word 0 moves to the holding register, neighbours of 0 are fetched
        cmd_o.cur_load  = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_addr_a = next_idx('0);
        cmd_o.rd_addr_b = far_idx('0);
        k_d             = '0;
        state_d         = S_TRUN;
      end
      S_TRUN: begin
        cmd_o.twist_wr = 1'b1;
        cmd_o.wr_addr  = k_q;
        cmd_o.cur_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        if (k_q == mtg_pkg::LAST_IDX) begin
          // twist finished: fetch word 0 for the pending draw
          cmd_o.rd_addr_a = '0;
          pos_d           = mtg_pkg::addr_t'(1);
          state_d         = S_DONE;
        end else begin
          cmd_o.rd_addr_a = next_idx(k_next);
          cmd_o.rd_addr_b = far_idx(k_next);
          k_d             = k_next;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_seed = (op_q == mtg_pkg::OP_SEED);
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.res_load || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= '0;
      pos_q       <= mtg_pkg::POS_UNSEEDED;
      op_q        <= mtg_pkg::OP_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/mtg_datapath.sv =====
// datapath: word table, seed chain, twist and tempering logic, result register
module mtg_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mtg_pkg::cmd_t  cmd_i,
  input  mtg_pkg::word_t seed_value_i,
  input  logic           cfg_we_i,
  input  mtg_pkg::word_t cfg_data_i,
  output mtg_pkg::word_t random_word_o,
  output logic           is_seed_ack_o
);

  mtg_pkg::word_t mem [mtg_pkg::TABLE_WORDS];
  mtg_pkg::word_t rd_a_q, rd_b_q;
  mtg_pkg::word_t cur_q;
  mtg_pkg::word_t chain_q, chain_d;
  mtg_pkg::word_t mix_q, mix_d;
  mtg_pkg::word_t fallback_q;
  mtg_pkg::word_t word_q, word_d;
  logic           ack_q;
  mtg_pkg::word_t fill_word, twist_word, wr_data, mix_lin, y;
  logic           wr_en;

  function automatic mtg_pkg::word_t temper(input mtg_pkg::word_t v);
    mtg_pkg::word_t t;
    t = v ^ (v >> 11);
    t = t ^ ((t << 7) & mtg_pkg::TEMPER_B);
    t = t ^ ((t << 15) & mtg_pkg::TEMPER_C);
    t = t ^ (t >> 18);
    return t;
  endfunction

  // seed chain and mixing sequence, one step per table word
  assign mix_lin   = mix_q * mtg_pkg::MIX_MULT + mtg_pkg::MIX_ADD;
  assign fill_word = cmd_i.fill_first ? chain_q : (chain_q ^ mix_q);

  always_comb begin
    chain_d = chain_q;
    mix_d   = mix_q;
    if (cmd_i.fill_init) begin
      chain_d = cmd_i.use_fallback ? fallback_q : seed_value_i;
      mix_d   = mtg_pkg::MIX_START;
    end else if (cmd_i.fill_wr) begin
      chain_d = chain_q * mtg_pkg::CHAIN_MULT;
      if (!cmd_i.fill_first) begin
        mix_d = mix_lin ^ (mix_lin >> 9) ^ (mix_lin << 19);
      end
    end
  end

  // twist of word k: cur holds old word k, port a word k+1, port b the far word
  assign y          = (cur_q & mtg_pkg::HIGH_BIT) | (rd_a_q & mtg_pkg::LOW_BITS);
  assign twist_word = rd_b_q ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);

  assign wr_en   = cmd_i.fill_wr || cmd_i.twist_wr;
  assign wr_data = cmd_i.fill_wr ? fill_word : twist_word;
  assign word_d  = cmd_i.res_seed ? '0 : temper(rd_a_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem[cmd_i.rd_addr_a];
      rd_b_q <= mem[cmd_i.rd_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    mix_q   <= mix_d;
    if (cmd_i.cur_load) begin
      cur_q <= rd_a_q;
    end
    if (cmd_i.res_load) begin
      word_q <= word_d;
      ack_q  <= cmd_i.res_seed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fallback_q <= 32'd1;
    end else if (cfg_we_i) begin
      fallback_q <= cfg_data_i;
    end
  end

  assign random_word_o = word_q;
  assign is_seed_ack_o = ack_q;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the mt19937 generator: seeds, draws and fallback seed writes
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    mtg_pkg::word_t random_word;
    logic           is_seed_ack;
  } rsp_word_t;

  // tracks the generator state and holds the words still owed by the block
  class mt_word_checker;
    mtg_pkg::word_t state_words [mtg_pkg::TABLE_WORDS];
    mtg_pkg::addr_t read_pos;
    mtg_pkg::word_t fallback;
    rsp_word_t      awaited[$];
    int             errors;

    function new();
      read_pos = mtg_pkg::POS_UNSEEDED;
      fallback = 32'd1;
      errors   = 0;
    endfunction

    function void set_fallback(mtg_pkg::word_t value);
      fallback = value;
    endfunction

    function void fill_from_seed(mtg_pkg::word_t seed);
      mtg_pkg::word_t mix;
      mix = mtg_pkg::MIX_START;
      state_words[0] = seed;
      for (int k = 1; k < mtg_pkg::TABLE_WORDS; k++) begin
        state_words[k] = state_words[k-1] * mtg_pkg::CHAIN_MULT;
      end
      for (int k = 1; k < mtg_pkg::TABLE_WORDS; k++) begin
        state_words[k] ^= mix;
        mix = mix * mtg_pkg::MIX_MULT + mtg_pkg::MIX_ADD;
        mix ^= (mix >> 9) ^ (mix << 19);
      end
      read_pos = mtg_pkg::POS_EXHAUSTED;
    endfunction

    function void twist_all();
      mtg_pkg::word_t y;
      int             nxt;
      int             far;
      for (int k = 0; k < mtg_pkg::TABLE_WORDS; k++) begin
        nxt = (k + 1) % mtg_pkg::TABLE_WORDS;
        far = (k + mtg_pkg::TWIST_OFFSET) % mtg_pkg::TABLE_WORDS;
        y = (state_words[k] & mtg_pkg::HIGH_BIT) | (state_words[nxt] & mtg_pkg::LOW_BITS);
        state_words[k] = state_words[far] ^ (y >> 1) ^
                         (y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
      end
      read_pos = '0;
    endfunction

    function mtg_pkg::word_t tempered(mtg_pkg::word_t raw);
      mtg_pkg::word_t y;
      y = raw;
      y ^= y >> 11;
      y ^= (y << 7) & mtg_pkg::TEMPER_B;
      y ^= (y << 15) & mtg_pkg::TEMPER_C;
      y ^= y >> 18;
      return y;
    endfunction

    function void note_request(logic op, mtg_pkg::word_t seed);
      rsp_word_t w;
      if (op == mtg_pkg::OP_SEED) begin
        fill_from_seed(seed);
        w.random_word = '0;
        w.is_seed_ack = 1'b1;
      end else begin
        // an unseeded table takes the fallback seed first
        if (read_pos >= mtg_pkg::POS_EXHAUSTED) begin
          if (read_pos != mtg_pkg::POS_EXHAUSTED) fill_from_seed(fallback);
          twist_all();
        end
        w.random_word = tempered(state_words[read_pos]);
        w.is_seed_ack = 1'b0;
        read_pos++;
      end
      awaited.push_back(w);
    endfunction

    function void check_response(mtg_pkg::word_t random_word, logic is_seed_ack);
      rsp_word_t w;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual random_word %h is_seed_ack %b",
                 $time, random_word, is_seed_ack);
        errors++;
        return;
      end
      w = awaited.pop_front();
      if (random_word !== w.random_word) begin
        $display("%0t: random_word expected %h actual %h", $time, w.random_word, random_word);
        errors++;
      end
      if (is_seed_ack !== w.is_seed_ack) begin
        $display("%0t: is_seed_ack expected %b actual %b", $time, w.is_seed_ack, is_seed_ack);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mtg_req_if req_if ();
  mtg_rsp_if rsp_if ();
  mtg_cfg_if cfg_if ();

  mersenne_twister_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  mt_word_checker chk = new();

  int items_sent   = 0;
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  bit quiet        = 1'b0;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // words moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni && req_if.valid && req_if.ready) chk.note_request(req_if.op, req_if.seed_value);
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      chk.check_response(rsp_if.random_word, rsp_if.is_seed_ack);
      results_seen++;
    end
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      rsp_if.ready = 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 500) begin
      rsp_if.ready = 1'b0;
      hold_left = 399;
      hold_done = 1'b1;
    end else begin
      rsp_if.ready = quiet || ($urandom_range(99) >= 13);
    end
  end

  task automatic send_request(logic op, mtg_pkg::word_t seed);
    int gap;
    gap = (quiet || $urandom_range(99) >= 13) ? 0 : $urandom_range(1, 6);
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.op         = op;
    req_if.seed_value = seed;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  task automatic draw_words(int count);
    repeat (count) send_request(mtg_pkg::OP_DRAW, $urandom);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_fallback(mtg_pkg::word_t value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data  = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    chk.set_fallback(value);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  function automatic mtg_pkg::word_t pick_seed();
    unique case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int             seg;
    int             writes;
    mtg_pkg::word_t value;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.op         = mtg_pkg::OP_SEED;
    req_if.seed_value = '0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // draw before any seed, off a written fallback
    write_fallback(32'hffffffff);
    draw_words(3);
    send_request(mtg_pkg::OP_SEED, 32'h0);
    draw_words(3);
    send_request(mtg_pkg::OP_SEED, 32'hffffffff);
    draw_words(2);
    // reseed mid-stream, then back to back seeds
    send_request(mtg_pkg::OP_SEED, 32'h5a5a5a5a);
    send_request(mtg_pkg::OP_SEED, 32'd1);
    draw_words(2);
    send_request(mtg_pkg::OP_SEED, 32'haaaaaaaa);
    draw_words(1);
    wait_drained();
    write_fallback(32'h0);

    seg    = 0;
    writes = 0;
    while (items_sent < 1320) begin
      if (seg % 6 == 5) begin
        wait_drained();
        case (writes % 4)
          0: value = $urandom;
          1: value = 32'h80000000;
          2: value = 32'hffffffff;
          default: value = 32'd1;
        endcase
        write_fallback(value);
        writes++;
      end
      quiet = (seg == 3);
      if (seg == 0 || $urandom_range(99) < 70) begin
        send_request(mtg_pkg::OP_SEED, pick_seed());
        if ($urandom_range(9) == 0) send_request(mtg_pkg::OP_SEED, pick_seed());
      end
      // one long run goes through a second twist
      draw_words((seg == 3) ? 700 : $urandom_range(4, 60));
      seg++;
    end
    quiet = 1'b0;

    wait_drained();
    write_fallback(32'd1);
    repeat (20) @(posedge clk_i);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("PASS mersenne_twister_generator");
    end else begin
      $display("FAIL mersenne_twister_generator");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL mersenne_twister_generator");
    $finish;
  end

endmodule
